### src/hyperbolic_moveout_index_unit_macros.svh
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: assertion macros
// Immediate-style wrappers for concurrent checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HYPERBOLIC_MOVEOUT_INDEX_UNIT_MACROS_SVH
`define HYPERBOLIC_MOVEOUT_INDEX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HMU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hmu check failed");
`define HMU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmu check failed");
`else
`define HMU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HMU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/hmu_pkg.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: package
// Payload, configuration, queue entry and status types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none
package hmu_pkg;

   localparam int NT_W   = 17;
   localparam int NQ_W   = 13;
   localparam int POSA_W = 22;
   localparam int IDX_W  = 20;
   localparam int POS_W  = 28;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;
   localparam int CSR_W  = 2;

   localparam logic [CSR_W-1:0] CSR_NUM_TIME        = 2'd0;
   localparam logic [CSR_W-1:0] CSR_NUM_CURVES      = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SAMPLE_INTERVAL = 2'd2;

   typedef struct packed {
      logic [31:0]        time_value;
      logic signed [23:0] offset_value;
      logic [31:0]        velocity_term;
      logic [11:0]        time_index;
      logic [7:0]         curve_index;
      logic [7:0]         offset_index;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] sparse_position;
      logic [IDX_W-1:0] data_index;
      logic [IDX_W-1:0] model_index;
      logic             valid_res;
   } rsp_type;

   typedef struct packed {
      logic [NT_W-1:0] nt;
      logic [NQ_W-1:0] nq;
      logic [31:0]     dt;
   } cfg_type;

   typedef struct packed {
      logic [46:0]       h2;
      logic [31:0]       vel;
      logic [63:0]       tsq;
      logic [11:0]       ti;
      logic [POSA_W-1:0] pos_a;
      logic [IDX_W-1:0]  model;
      logic [IDX_W-1:0]  data_base;
      logic              ok;
   } qent_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic [POS_W-1:0] sparse;
      logic [IDX_W-1:0] data_base;
      logic [IDX_W-1:0] model;
      logic             ok;
   } sb_type;

endpackage
`default_nettype wire

### src/hmu_front.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: front end
// Accept requests, square time and offset, form indices and classify.
// ----------------------------------------------------------------------------
`default_nettype none
module hmu_front #(
   parameter int MAX_OFFSETS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hmu_pkg::req_type  req_data,
   input  wire hmu_pkg::cfg_type  cfg,
   input  wire logic              q_full,
   output logic                   q_push,
   output hmu_pkg::qent_type      q_data
);
   import hmu_pkg::*;

   logic     fv_ff, fv_in;
   qent_type fd_ff, fd_in;
   logic [23:0] raw, habs;
   logic        oi_ok;

   assign q_push    = fv_ff && !q_full;
   assign req_ready = !fv_ff || !q_full;
   assign q_data    = fd_ff;

   always_comb begin
      raw   = req_data.offset_value;
      habs  = raw[23] ? (24'd0 - raw) : raw;
      oi_ok = 32'(req_data.offset_index) < 32'(MAX_OFFSETS);
      fd_in.h2    = 47'(48'(habs) * 48'(habs));
      fd_in.vel   = req_data.velocity_term;
      fd_in.tsq   = 64'(req_data.time_value) * 64'(req_data.time_value);
      fd_in.ti    = req_data.time_index;
      fd_in.pos_a = POSA_W'(req_data.offset_index) * POSA_W'(cfg.nq)
                    + POSA_W'(req_data.curve_index);
      fd_in.model = IDX_W'(IDX_W'(req_data.curve_index) * IDX_W'(cfg.nt)
                    + IDX_W'(req_data.time_index));
      fd_in.data_base = IDX_W'(IDX_W'(req_data.offset_index) * IDX_W'(cfg.nt));
      fd_in.ok = (req_data.velocity_term != 32'd0) && (cfg.dt != 32'd0)
                 && (NT_W'(req_data.time_index) < cfg.nt)
                 && (NQ_W'(req_data.curve_index) < cfg.nq) && oi_ok;
   end

   always_comb begin
      fv_in = fv_ff;
      if (req_valid && req_ready) begin
         fv_in = 1'b1;
      end else if (q_push) begin
         fv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         fd_ff <= fd_in;
      end
   end
endmodule
`default_nettype wire

### src/hmu_queue.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: decoupling queue
// Short FIFO between the front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module hmu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire hmu_pkg::qent_type  push_data,
   input  wire logic               pop,
   output hmu_pkg::qent_type       pop_data,
   output hmu_pkg::qstat_type      stat
);
   import hmu_pkg::*;

   qent_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign stat.full  = cnt_ff == QCNT_W'(QDEPTH);
   assign stat.empty = cnt_ff == '0;
   assign stat.count = cnt_ff;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### src/hmu_back.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: arithmetic pipeline
// Divide by velocity, root, round to a sample index, form the result.
// ----------------------------------------------------------------------------
`default_nettype none
module hmu_back #(
   parameter int MAX_TIME = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hmu_pkg::cfg_type   cfg,
   input  wire hmu_pkg::qstat_type q_stat,
   input  wire hmu_pkg::qent_type  q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hmu_pkg::rsp_type        rsp_data
);
   import hmu_pkg::*;

   localparam int DIV_N = 79;
   localparam int SQ_N  = 40;
   localparam int QW    = $clog2(MAX_TIME);
   localparam int QDW   = (34 + QW > 42) ? 34 + QW : 42;
   localparam int L     = DIV_N + 1 + SQ_N + 2 + QW + 1;

   logic         en;
   logic [L-1:0] v_ff, v_in;
   sb_type       sb0;

   logic [31:0] drem [DIV_N];
   logic [78:0] dw   [DIV_N];
   logic [31:0] dvel [DIV_N];
   logic [63:0] dtsq [DIV_N];
   sb_type      dsb  [DIV_N];

   logic [79:0] s_ff;
   sb_type      ssb_ff;

   logic [41:0] srem [SQ_N];
   logic [39:0] sroot[SQ_N];
   logic [79:0] srad [SQ_N];
   sb_type      qsb  [SQ_N];

   logic [41:0] num_ff, num2_ff;
   logic [49:0] lim_ff;
   sb_type      nsb_ff, csb_ff;

   logic [41:0]   krem [QW];
   logic [QW-1:0] kq   [QW];
   sb_type        ksb  [QW];

   rsp_type rsp_ff, rsp_in;
   logic [32:0] dd;

   assign en        = !v_ff[L-1] || rsp_ready;
   assign q_pop     = en && !q_stat.empty;
   assign rsp_valid = v_ff[L-1];
   assign rsp_data  = rsp_ff;
   assign dd        = {cfg.dt, 1'b0};

   always_comb begin
      sb0.sparse    = POS_W'(40'(q_data.pos_a) * 40'(cfg.nt) + 40'(q_data.ti));
      sb0.data_base = q_data.data_base;
      sb0.model     = q_data.model;
      sb0.ok        = q_data.ok;
   end

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [31:0] rem_src, vel_src, rem_ff, rem_in, vel_ff;
      logic [78:0] w_src, w_ff, w_in;
      logic [63:0] tsq_src, tsq_ff;
      sb_type      sb_src, sb_ff;
      logic [32:0] rem_ext;
      logic        ge;
      if (j == 0) begin : g_src
         always_comb begin
            rem_src = '0;
            w_src   = {q_data.h2, 32'd0};
            vel_src = q_data.vel;
            tsq_src = q_data.tsq;
            sb_src  = sb0;
         end
      end else begin : g_src
         always_comb begin
            rem_src = drem[j-1];
            w_src   = dw[j-1];
            vel_src = dvel[j-1];
            tsq_src = dtsq[j-1];
            sb_src  = dsb[j-1];
         end
      end
      always_comb begin
         rem_ext = {rem_src, w_src[78]};
         ge      = rem_ext >= {1'b0, vel_src};
         rem_in  = ge ? 32'(rem_ext - {1'b0, vel_src}) : rem_ext[31:0];
         w_in    = {w_src[77:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            w_ff   <= w_in;
            vel_ff <= vel_src;
            tsq_ff <= tsq_src;
            sb_ff  <= sb_src;
         end
      end
      assign drem[j] = rem_ff;
      assign dw[j]   = w_ff;
      assign dvel[j] = vel_ff;
      assign dtsq[j] = tsq_ff;
      assign dsb[j]  = sb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= 80'(dw[DIV_N-1]) + 80'(dtsq[DIV_N-1]);
         ssb_ff <= dsb[DIV_N-1];
      end
   end

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      logic [41:0] rem_src, rem_ff, rem_in, re, trial;
      logic [39:0] root_src, root_ff, root_in;
      logic [79:0] rad_src, rad_ff;
      sb_type      sb_src, sb_ff;
      logic        ge;
      if (j == 0) begin : g_src
         always_comb begin
            rem_src  = '0;
            root_src = '0;
            rad_src  = s_ff;
            sb_src   = ssb_ff;
         end
      end else begin : g_src
         always_comb begin
            rem_src  = srem[j-1];
            root_src = sroot[j-1];
            rad_src  = srad[j-1];
            sb_src   = qsb[j-1];
         end
      end
      always_comb begin
         re      = {rem_src[39:0], rad_src[79:78]};
         trial   = {root_src, 2'b01};
         ge      = re >= trial;
         rem_in  = ge ? re - trial : re;
         root_in = {root_src[38:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= {rad_src[77:0], 2'b00};
            sb_ff   <= sb_src;
         end
      end
      assign srem[j]  = rem_ff;
      assign sroot[j] = root_ff;
      assign srad[j]  = rad_ff;
      assign qsb[j]   = sb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= 42'({sroot[SQ_N-1], 1'b0}) + 42'(cfg.dt);
         lim_ff  <= 50'(cfg.nt) * 50'(dd);
         nsb_ff  <= qsb[SQ_N-1];
         num2_ff <= num_ff;
         csb_ff  <= {nsb_ff.sparse, nsb_ff.data_base, nsb_ff.model,
                     nsb_ff.ok && (50'(num_ff) < lim_ff)};
      end
   end

   for (genvar m = 0; m < QW; m++) begin : g_quo
      localparam int B = QW - 1 - m;
      logic [41:0]    rem_src, rem_ff, rem_in;
      logic [QW-1:0]  k_src, k_ff, k_in;
      sb_type         sb_src, sb_ff;
      logic [QDW-1:0] sh;
      logic           ge;
      if (m == 0) begin : g_src
         always_comb begin
            rem_src = num2_ff;
            k_src   = '0;
            sb_src  = csb_ff;
         end
      end else begin : g_src
         always_comb begin
            rem_src = krem[m-1];
            k_src   = kq[m-1];
            sb_src  = ksb[m-1];
         end
      end
      always_comb begin
         sh      = QDW'(dd) << B;
         ge      = QDW'(rem_src) >= sh;
         rem_in  = ge ? 42'(QDW'(rem_src) - sh) : rem_src;
         k_in    = k_src;
         k_in[B] = ge;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            k_ff   <= k_in;
            sb_ff  <= sb_src;
         end
      end
      assign krem[m] = rem_ff;
      assign kq[m]   = k_ff;
      assign ksb[m]  = sb_ff;
   end

   always_comb begin
      rsp_in.sparse_position = ksb[QW-1].sparse;
      rsp_in.valid_res       = ksb[QW-1].ok;
      rsp_in.data_index      = ksb[QW-1].ok
                               ? IDX_W'(ksb[QW-1].data_base + IDX_W'(kq[QW-1])) : '0;
      rsp_in.model_index     = ksb[QW-1].ok ? ksb[QW-1].model : '0;
      v_in = {v_ff[L-2:0], !q_stat.empty};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end
endmodule
`default_nettype wire

### src/hyperbolic_moveout_index_unit.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: top level
// Builds one sparse-operator entry of a hyperbolic Radon transform per request.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    hmu_pkg::req_type
//   rsp_     out        rsp_valid/rsp_ready    hmu_pkg::rsp_type
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// One request per cycle sustained while results are taken; the pipeline holds the
// 79-step velocity divider, the 40-step root and the rounding divide.
// A four-entry queue parts the front end from the pipeline; a stalled result
// freezes the pipeline while the front end keeps accepting until the queue fills.
// Reset clears control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hyperbolic_moveout_index_unit_macros.svh"
module hyperbolic_moveout_index_unit #(
   parameter int MAX_TIME    = 4096,
   parameter int MAX_CURVES  = 256,
   parameter int MAX_OFFSETS = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire hmu_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output hmu_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [hmu_pkg::CSR_W-1:0] csr_index,
   input  wire logic [31:0]               csr_data
);
   import hmu_pkg::*;

   logic [12:0] num_time_ff, num_time_in;
   logic [8:0]  num_curves_ff, num_curves_in;
   logic [31:0] sample_interval_ff, sample_interval_in;
   cfg_type     cfg;
   logic        q_push, q_pop;
   qent_type    q_in, q_out;
   qstat_type   q_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      num_time_in        = num_time_ff;
      num_curves_in      = num_curves_ff;
      sample_interval_in = sample_interval_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_TIME:        num_time_in        = csr_data[12:0];
            CSR_NUM_CURVES:      num_curves_in      = csr_data[8:0];
            CSR_SAMPLE_INTERVAL: sample_interval_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_time_ff        <= 13'd1024;
         num_curves_ff      <= 9'd64;
         sample_interval_ff <= 32'd67109;
      end else begin
         num_time_ff        <= num_time_in;
         num_curves_ff      <= num_curves_in;
         sample_interval_ff <= sample_interval_in;
      end
   end

   always_comb begin
      cfg.nt = (32'(num_time_ff) < 32'(MAX_TIME)) ? NT_W'(num_time_ff) : NT_W'(MAX_TIME);
      cfg.nq = (32'(num_curves_ff) < 32'(MAX_CURVES))
               ? NQ_W'(num_curves_ff) : NQ_W'(MAX_CURVES);
      cfg.dt = sample_interval_ff;
   end

   hmu_front #(.MAX_OFFSETS(MAX_OFFSETS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_stat.full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   hmu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .stat      (q_stat)
   );

   hmu_back #(.MAX_TIME(MAX_TIME)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `HMU_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !rsp_data.valid_res, rsp_data.data_index == '0 && rsp_data.model_index == '0)
   `HMU_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
   `HMU_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty)
   `HMU_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && q_stat.empty)
endmodule
`default_nettype wire

### bench/tb_hyperbolic_moveout_index_unit.sv
// ----------------------------------------------------------------------------
// Hyperbolic moveout index unit: testbench
// Drives requests and register writes through the valid/ready channels and
// predicts every sparse-operator entry with a bit-exact model of the moveout
// arithmetic. Results are checked in order, field by field, under several
// register settings and several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_hyperbolic_moveout_index_unit;
   import hmu_pkg::*;

   localparam int TIME_CAP   = 4096;
   localparam int CURVE_CAP  = 256;
   localparam int OFFSET_CAP = 256;
   localparam int LATENCY    = 150;

   class moveout_scoreboard;
      rsp_type     pending[$];
      int          errors;
      int          checked;
      int          valid_seen;
      logic [12:0] num_time;
      logic [8:0]  num_curves;
      logic [31:0] dt;

      function new();
         num_time   = 13'd1024;
         num_curves = 9'd64;
         dt         = 32'd67109;
      endfunction

      function void write_reg(logic [CSR_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_NUM_TIME:        num_time   = value[12:0];
            CSR_NUM_CURVES:      num_curves = value[8:0];
            CSR_SAMPLE_INTERVAL: dt         = value;
            default: ;
         endcase
      endfunction

      function logic [39:0] root_floor(logic [79:0] s);
         logic [39:0] root;
         logic [39:0] trial;
         root = '0;
         for (int i = 39; i >= 0; i--) begin
            trial = root | (40'd1 << i);
            if ({40'd0, trial} * {40'd0, trial} <= s) root = trial;
         end
         return root;
      endfunction

      function void note_request(req_type r);
         logic [63:0] nt, nq, k, tp, sparse;
         logic [23:0] habs;
         logic [79:0] h2, quot, sum;
         logic        ok;
         rsp_type     e;
         nt   = (num_time < TIME_CAP) ? num_time : TIME_CAP;
         nq   = (num_curves < CURVE_CAP) ? num_curves : CURVE_CAP;
         habs = r.offset_value[23] ? -r.offset_value : r.offset_value;
         h2   = {56'd0, habs} * {56'd0, habs};
         k    = '0;
         ok   = 1'b0;
         if (r.velocity_term != 0 && dt != 0 && r.time_index < nt &&
             r.curve_index < nq && r.offset_index < OFFSET_CAP) begin
            quot = (h2 << 32) / {48'd0, r.velocity_term};
            sum  = quot + {48'd0, r.time_value} * {48'd0, r.time_value};
            tp   = {24'd0, root_floor(sum)};
            k    = (2 * tp + {32'd0, dt}) / (2 * {32'd0, dt});
            ok   = k < nt;
         end
         sparse = ({56'd0, r.offset_index} * nq + r.curve_index) * nt + r.time_index;
         e.sparse_position = sparse[POS_W-1:0];
         e.data_index      = ok ? IDX_W'({56'd0, r.offset_index} * nt + k) : '0;
         e.model_index     = ok ? IDX_W'({56'd0, r.curve_index} * nt + r.time_index) : '0;
         e.valid_res       = ok;
         pending.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %0s: got %0h, want %0h (result %0d)", what, got, want, checked);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected transfer", got.sparse_position, 0);
            return;
         end
         want = pending.pop_front();
         if (got.sparse_position !== want.sparse_position)
            report("sparse_position", got.sparse_position, want.sparse_position);
         if (got.data_index !== want.data_index)
            report("data_index", got.data_index, want.data_index);
         if (got.model_index !== want.model_index)
            report("model_index", got.model_index, want.model_index);
         if (got.valid_res !== want.valid_res)
            report("valid_res", got.valid_res, want.valid_res);
         valid_seen += want.valid_res;
         checked++;
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_index = CSR_NUM_TIME;
   logic [31:0]      csr_data = '0;

   int idle_pct  = 0;
   int stall_pct = 0;

   moveout_scoreboard sb = new();

   hyperbolic_moveout_index_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_request(req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   function automatic req_type make_request(bit shaped);
      req_type     r;
      logic [63:0] nt, nq, tv;
      nt = (sb.num_time < TIME_CAP) ? sb.num_time : TIME_CAP;
      nq = (sb.num_curves < CURVE_CAP) ? sb.num_curves : CURVE_CAP;
      r.time_value    = $urandom;
      r.offset_value  = 24'($urandom);
      r.velocity_term = $urandom;
      r.time_index    = 12'($urandom);
      r.curve_index   = 8'($urandom);
      r.offset_index  = 8'($urandom);
      if (shaped) begin
         r.time_index   = 12'($urandom_range(0, int'(nt) - 1));
         r.curve_index  = 8'($urandom_range(0, int'(nq) - 1));
         tv = {32'd0, r.time_index} * sb.dt;
         if ($urandom_range(0, 3) != 0) tv = tv + ($urandom % (sb.dt + 64'd1));
         r.time_value   = tv[31:0];
         r.offset_value = $signed(r.offset_value) >>> $urandom_range(0, 23);
         r.velocity_term = r.velocity_term >> $urandom_range(0, 31);
         if (r.velocity_term == 0) r.velocity_term = 32'd1;
      end
      return r;
   endfunction

   initial begin
      req_type     r;
      logic [31:0] nt_set [6];
      logic [31:0] nq_set [6];
      logic [31:0] dt_set [6];
      int          n;
      nt_set = '{32'd4096, 32'd2,  32'd8191, 32'd1000, 32'd300, 32'd64};
      nq_set = '{32'd256,  32'd1,  32'd511,  32'd100,  32'd37,  32'd200};
      dt_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd67109, $urandom_range(2, 1 << 20), 32'd4000};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners under the reset settings
      for (int i = 0; i < 22; i++) begin
         r = make_request(1'b1);
         case (i)
            0: r.time_value = '0;
            1: r.time_value = '1;
            2: r.offset_value = 24'sh800000;
            3: r.offset_value = 24'sh7FFFFF;
            4: r.velocity_term = '0;
            5: r.velocity_term = 32'd1;
            6: r.velocity_term = '1;
            7: r.time_index = 12'd1023;
            8: r.time_index = 12'd1024;
            9: r.time_index = 12'hFFF;
            10: r.curve_index = 8'd63;
            11: r.curve_index = 8'd64;
            12: r.offset_index = 8'hFF;
            13: r.offset_index = 8'd0;
            14: begin
               r.offset_value = '0;
               r.time_value = 32'd67109 * 1023 + 32'd33554;
            end
            15: begin
               r.offset_value = '0;
               r.time_value = 32'd67109 * 1023 + 32'd33555;
            end
            16: begin
               r.offset_value = '0;
               r.time_value = 32'd67109 * 5 + 32'd33554;
            end
            17: begin
               r.offset_value = 24'sh800000;
               r.velocity_term = 32'd1;
               r.time_value = '1;
            end
            default: r = make_request(1'b0);
         endcase
         send_request(r);
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_csr(CSR_SAMPLE_INTERVAL, dt_set[ph]);
         write_csr(CSR_NUM_TIME, nt_set[ph]);
         write_csr(CSR_NUM_CURVES, nq_set[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         n = 275;
         for (int i = 0; i < n; i++) begin
            if (i == n / 2 && ph == 1) wait_drained();
            send_request(make_request($urandom_range(0, 99) < 80));
         end
      end

      wait_drained();
      repeat (LATENCY) @(posedge clock);
      $display("covered %0d entries (%0d valid) over 7 register settings", sb.checked,
               sb.valid_seen);
      $display("idling mixes: none, sender only, receiver only, both");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
